### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the case-folded hash checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge once reset is released.
`define CFAH_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cfah assertion failed");

// Checked on every rising edge, reset included.
`define CFAH_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cfah assertion failed");

`endif

### design/cfah_pkg.sv
// ----------------------------------------------------------------------------
// cfah_pkg
// Types, constants and helper functions of the case-folded Adler hash.
// ----------------------------------------------------------------------------
package cfah_pkg;

  localparam logic [15:0] ModBase = 16'd65521;

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // One classified request as it travels from the front end to the back end.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } cfah_item_t;

  // Queue status as seen by the front and back ends.
  typedef struct packed {
    logic full;
    logic not_empty;
  } cfah_q_status_t;

  // Upper-case ASCII letters map to lower case; every other byte passes.
  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

  // Both operands are below the modulus, so one conditional subtract suffices.
  function automatic logic [15:0] add_mod(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, ModBase}) begin
      s = s - {1'b0, ModBase};
    end
    return s[15:0];
  endfunction

endpackage

### design/cfah_front.sv
// ----------------------------------------------------------------------------
// cfah_front
// Accepts input requests, folds case and drops items that carry no work.
// ----------------------------------------------------------------------------
module cfah_front (
  input  logic                   s_valid_i,
  input  logic [7:0]             s_data_byte_i,
  input  logic                   s_has_byte_i,
  input  logic                   s_last_i,
  output logic                   s_ready_o,
  input  cfah_pkg::cfah_q_status_t q_status_i,
  output logic                   push_o,
  output cfah_pkg::cfah_item_t   push_item_o
);
  import cfah_pkg::*;

  assign s_ready_o = !q_status_i.full;

  // An item with neither a byte nor the end mark leaves the state alone.
  assign push_o = s_valid_i && s_ready_o && (s_has_byte_i || s_last_i);

  assign push_item_o.data_byte = fold_case(s_data_byte_i);
  assign push_item_o.has_byte  = s_has_byte_i;
  assign push_item_o.last      = s_last_i;

endmodule

### design/cfah_queue.sv
// ----------------------------------------------------------------------------
// cfah_queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module cfah_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  cfah_pkg::cfah_item_t     push_item_i,
  input  logic                     pop_i,
  output cfah_pkg::cfah_item_t     head_item_o,
  output cfah_pkg::cfah_q_status_t status_o
);
  import cfah_pkg::*;

  cfah_item_t             entry_q [QDepth];
  logic [QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]       cnt_q, cnt_d;

  assign status_o.full      = (cnt_q == QCntW'(QDepth));
  assign status_o.not_empty = (cnt_q != '0);
  assign head_item_o        = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### design/cfah_back.sv
// ----------------------------------------------------------------------------
// cfah_back
// Updates both running sums and holds the finished hash for the output.
// ----------------------------------------------------------------------------
module cfah_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfah_pkg::cfah_q_status_t q_status_i,
  input  cfah_pkg::cfah_item_t     head_item_i,
  output logic                     pop_o,
  output logic                     m_valid_o,
  input  logic                     m_ready_i,
  output logic [31:0]              m_hash_value_o
);
  import cfah_pkg::*;

  logic [15:0] low_sum_q, low_sum_d;
  logic [15:0] high_sum_q, high_sum_d;
  logic [15:0] low_new, high_new;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_hash_q, out_hash_d;

  // Only an end item needs the output register; it waits while a held hash is not yet taken.
  assign pop_o = q_status_i.not_empty &&
                 (!head_item_i.last || !out_valid_q || m_ready_i);

  assign low_new  = head_item_i.has_byte ?
                    add_mod(low_sum_q, {8'h00, head_item_i.data_byte}) : low_sum_q;
  assign high_new = head_item_i.has_byte ? add_mod(high_sum_q, low_new) : high_sum_q;

  always_comb begin
    low_sum_d   = low_sum_q;
    high_sum_d  = high_sum_q;
    out_hash_d  = out_hash_q;
    out_valid_d = out_valid_q && !m_ready_i;
    if (pop_o) begin
      if (head_item_i.last) begin
        out_hash_d  = {high_new, low_new};
        out_valid_d = 1'b1;
        low_sum_d   = '0;
        high_sum_d  = '0;
      end else begin
        low_sum_d  = low_new;
        high_sum_d = high_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_sum_q   <= '0;
      high_sum_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      low_sum_q   <= low_sum_d;
      high_sum_q  <= high_sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_hash_q <= out_hash_d;
  end

  assign m_valid_o      = out_valid_q;
  assign m_hash_value_o = out_hash_q;

endmodule

### design/case_folded_adler_hash.sv
// ----------------------------------------------------------------------------
// case_folded_adler_hash
// Case-insensitive Adler-32 style hash of an identifier, one byte a request.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Request content
//   s_axis    in         tdata = data_byte, tuser = has_byte, tlast = last
//   m_axis    out        tdata = hash_value (high sum 31..16, low sum 15..0)
//
// The block takes one input request per cycle while its queue is not full,
// and an end request produces its hash in the output register at the same
// edge at which it leaves the two-entry queue. Its pace is set by the back
// end, which folds each byte into both registered sums through two
// add-and-reduce steps in a chain.
// Reset is asynchronous and active low; it clears both sums and all valid
// state, and no clearing pass follows, so a request is taken right away.
// While a finished hash waits on m_axis, byte requests keep flowing; the
// queue fills only when a second end request meets the held hash.
// ----------------------------------------------------------------------------
module case_folded_adler_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] has_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [31:0] hash_value
);
  import cfah_pkg::*;

  cfah_q_status_t q_status;
  cfah_item_t     push_item;
  cfah_item_t     head_item;
  logic           push;
  logic           pop;

  // The front end folds case and filters out requests that carry no work.
  cfah_front u_front (
    .s_valid_i     (s_axis_tvalid_i),
    .s_data_byte_i (s_axis_tdata_i),
    .s_has_byte_i  (s_axis_tuser_i),
    .s_last_i      (s_axis_tlast_i),
    .s_ready_o     (s_axis_tready_o),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  // The queue lets the input side run while the output side is stalled.
  cfah_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_item_o (head_item),
    .status_o    (q_status)
  );

  // The back end keeps the sums modulo 65521 and emits the hash on an end request.
  cfah_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .head_item_i    (head_item),
    .pop_o          (pop),
    .m_valid_o      (m_axis_tvalid_o),
    .m_ready_i      (m_axis_tready_i),
    .m_hash_value_o (m_axis_tdata_o)
  );

endmodule

### design/cfah_checker.sv
// ----------------------------------------------------------------------------
// cfah_checker
// Port-level checks of the case-folded hash, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfah_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);

  // A held hash stays offered until it is taken.
  `CFAH_ASSERT(a_out_valid_holds, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)

  // A held hash does not change while it waits.
  `CFAH_ASSERT(a_out_data_holds, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))

  // The input side backs up only behind a hash that the output side has not taken.
  `CFAH_ASSERT(a_backpressure_cause, clk_i, rst_ni, !s_axis_tready_o |-> m_axis_tvalid_o)

  // Once reset has been seen at an edge, no result is offered at the next one.
  `CFAH_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !m_axis_tvalid_o)

endmodule

bind case_folded_adler_hash cfah_checker u_cfah_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
